@@ sv/cc_cv_charge_regulator_macros.svh @@
// Assertion macros shared by the charge regulator RTL.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef CC_CV_CHARGE_REGULATOR_MACROS_SVH
`define CC_CV_CHARGE_REGULATOR_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CCR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("ccr check failed");

// Next-cycle implication, disabled while reset is asserted.
`define CCR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("ccr check failed");

`endif

@@ sv/ccr_pkg.sv @@
// Shared types and constants of the CC/CV charge regulator.
// No dependencies; used by ccr_step and cc_cv_charge_regulator.
package ccr_pkg;

    // input opcodes
    localparam logic [1:0] OP_START  = 2'd0;
    localparam logic [1:0] OP_SAMPLE = 2'd1;
    localparam logic [1:0] OP_TICK   = 2'd2;

    // charger modes
    localparam logic [1:0] MODE_IDLE       = 2'd0;
    localparam logic [1:0] MODE_STARTING   = 2'd1;
    localparam logic [1:0] MODE_REGULATING = 2'd2;
    localparam logic [1:0] MODE_STOPPING   = 2'd3;

    localparam logic PHASE_CC = 1'b0;
    localparam logic PHASE_CV = 1'b1;

    // configuration register indexes
    localparam logic [2:0] REG_CC_CURRENT     = 3'd0;
    localparam logic [2:0] REG_CV_VOLTAGE     = 3'd1;
    localparam logic [2:0] REG_CC_END_VOLTAGE = 3'd2;
    localparam logic [2:0] REG_CV_END_CURRENT = 3'd3;
    localparam logic [2:0] REG_DEAD_BAND      = 3'd4;

    localparam int LEVEL_BITS = 12;
    localparam int ERR_BITS   = 18;

    localparam logic [15:0] WORD_ACTIVE = 16'h1000;
    localparam logic [15:0] OFF_WORD_A  = 16'h1FFF;
    localparam logic [15:0] OFF_WORD_B  = 16'h5000;

    localparam logic signed [ERR_BITS-1:0] ERR_BIG     = 18'sd100;
    localparam logic signed [ERR_BITS-1:0] ERR_BIG_NEG = -18'sd100;

    localparam logic [1:0] KIND_DAC  = 2'd0;
    localparam logic       KIND_DONE = 1'b1;

    typedef struct packed {
        logic [14:0] cc_current_ma;
        logic [15:0] cv_voltage_mv;
        logic [15:0] cc_end_voltage_mv;
        logic [14:0] cv_end_current_ma;
        logic [11:0] dead_band;
    } t_cfg;

    typedef struct packed {
        logic [1:0]  mode;
        logic        phase;
        logic [31:0] seconds;
    } t_ctl;

    // results caused by one item: none, one DAC word, or the stop burst
    typedef struct packed {
        logic [1:0]  count;
        logic        stop;
        logic [15:0] word;
        logic [31:0] secs;
    } t_emit;

endpackage

@@ sv/ccr_step.sv @@
// Combinational next-state and result logic for one input beat.
// Depends on ccr_pkg.
module ccr_step #(
    parameter int DRIVE_BITS = 12
) (
    input  ccr_pkg::t_cfg          i_cfg,
    input  ccr_pkg::t_ctl          i_ctl,
    input  logic [DRIVE_BITS-1:0]  i_drive,
    input  logic [1:0]             i_opcode,
    input  logic [15:0]            i_meas_voltage_mv,
    input  logic signed [15:0]     i_meas_current_ma,
    output ccr_pkg::t_ctl          o_ctl,
    output logic [DRIVE_BITS-1:0]  o_drive,
    output ccr_pkg::t_emit         o_emit
);

    localparam logic [DRIVE_BITS-1:0] DriveMax = {DRIVE_BITS{1'b1}};

    logic signed [ccr_pkg::ERR_BITS-1:0] w_err;
    logic signed [ccr_pkg::ERR_BITS-1:0] w_tol;
    logic [DRIVE_BITS-1:0]               w_rate;
    logic [DRIVE_BITS-1:0]               w_reg_drive;
    logic [16:0]                         w_cur_ext;
    logic [16:0]                         w_cur_mag;
    logic                                w_exit;
    logic [ccr_pkg::LEVEL_BITS+DRIVE_BITS-1:0] w_lvl_wide;

    always_comb begin
        if (i_ctl.phase == ccr_pkg::PHASE_CC) begin
            w_err = $signed({3'b000, i_cfg.cc_current_ma})
                  - $signed({{2{i_meas_current_ma[15]}}, i_meas_current_ma});
        end else begin
            w_err = $signed({2'b00, i_cfg.cv_voltage_mv})
                  - $signed({2'b00, i_meas_voltage_mv});
        end
    end

    assign w_tol  = $signed({6'b000000, i_cfg.dead_band});
    assign w_rate = (w_err >= ccr_pkg::ERR_BIG || w_err <= ccr_pkg::ERR_BIG_NEG)
                  ? DRIVE_BITS'(10) : DRIVE_BITS'(1);

    // step toward target, saturating at 0 and full scale
    always_comb begin
        w_reg_drive = i_drive;
        if (w_err > w_tol && i_drive != '0) begin
            w_reg_drive = (i_drive > w_rate) ? i_drive - w_rate : '0;
        end else if (w_err < -w_tol && i_drive != DriveMax) begin
            w_reg_drive = (DriveMax - i_drive > w_rate) ? i_drive + w_rate : DriveMax;
        end
    end

    assign w_cur_ext = {i_meas_current_ma[15], i_meas_current_ma};
    assign w_cur_mag = i_meas_current_ma[15] ? (17'd0 - w_cur_ext) : w_cur_ext;

    assign w_exit = (i_ctl.phase == ccr_pkg::PHASE_CC)
                  ? (i_meas_voltage_mv >= i_cfg.cc_end_voltage_mv)
                  : (w_cur_mag <= {2'b00, i_cfg.cv_end_current_ma});

    assign w_lvl_wide = {{ccr_pkg::LEVEL_BITS{1'b0}}, w_reg_drive};

    always_comb begin
        o_ctl  = i_ctl;
        o_drive = i_drive;
        o_emit = '0;
        case (i_opcode)
            ccr_pkg::OP_START: begin
                o_ctl.mode = ccr_pkg::MODE_STARTING;
            end
            ccr_pkg::OP_TICK: begin
                if (i_ctl.mode inside {ccr_pkg::MODE_REGULATING, ccr_pkg::MODE_STOPPING}
                    && i_ctl.seconds != 32'hFFFF_FFFF) begin
                    o_ctl.seconds = i_ctl.seconds + 32'd1;
                end
            end
            ccr_pkg::OP_SAMPLE: begin
                case (i_ctl.mode)
                    ccr_pkg::MODE_STARTING: begin
                        o_drive       = DriveMax;
                        o_ctl.phase   = ccr_pkg::PHASE_CC;
                        o_ctl.seconds = '0;
                        o_ctl.mode    = ccr_pkg::MODE_REGULATING;
                    end
                    ccr_pkg::MODE_REGULATING: begin
                        if (w_exit) begin
                            if (i_ctl.phase == ccr_pkg::PHASE_CC) begin
                                o_ctl.phase = ccr_pkg::PHASE_CV;
                            end else begin
                                o_ctl.mode = ccr_pkg::MODE_STOPPING;
                            end
                        end else begin
                            o_drive      = w_reg_drive;
                            o_emit.count = 2'd1;
                            o_emit.word  = ccr_pkg::WORD_ACTIVE
                                         | {4'b0000, w_lvl_wide[ccr_pkg::LEVEL_BITS-1:0]};
                        end
                    end
                    ccr_pkg::MODE_STOPPING: begin
                        o_emit.count = 2'd3;
                        o_emit.stop  = 1'b1;
                        o_emit.secs  = i_ctl.seconds;
                        o_ctl.mode   = ccr_pkg::MODE_IDLE;
                    end
                    default: begin
                    end
                endcase
            end
            default: begin
            end
        endcase
    end

endmodule

@@ sv/cc_cv_charge_regulator.sv @@
// CC/CV charge regulator, one channel. An input beat is registered, then one
// pass of ccr_step updates the charger state and loads the result register.
// Throughput is one input beat per cycle while results drain. A stop sample
// fills the result register with a three-beat burst (done report, two off
// words), so the output port and its ready set the rate: it holds further
// samples for up to three output beats. Config writes take effect on the
// next edge.
// Depends on ccr_pkg, ccr_step and cc_cv_charge_regulator_macros.svh.
`include "cc_cv_charge_regulator_macros.svh"

module cc_cv_charge_regulator #(
    parameter int DRIVE_BITS = 12
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [2:0]         i_cfg_idx,
    input  logic [15:0]        i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [1:0]         i_opcode,
    input  logic [15:0]        i_meas_voltage_mv,
    input  logic signed [15:0] i_meas_current_ma,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic               o_kind,
    output logic [15:0]        o_spi_word,
    output logic [31:0]        o_elapsed_seconds,
    output logic               o_last
);

    localparam logic [DRIVE_BITS-1:0] DriveMax = {DRIVE_BITS{1'b1}};

    ccr_pkg::t_cfg r_cfg;

    // input register
    logic               r_in_valid;
    logic [1:0]         r_opcode;
    logic [15:0]        r_volt;
    logic signed [15:0] r_cur;

    // charger state
    ccr_pkg::t_ctl          r_ctl;
    logic [DRIVE_BITS-1:0]  r_drive;
    ccr_pkg::t_ctl          w_ctl;
    logic [DRIVE_BITS-1:0]  w_drive;
    ccr_pkg::t_emit         w_emit;

    // result register: remaining beats of the current burst
    logic [1:0]  r_cnt;
    logic [1:0]  n_cnt;
    logic        r_stop;
    logic [15:0] r_word;
    logic [31:0] r_secs;

    logic w_pop;
    logic w_free;
    logic w_advance;
    logic w_load;

    ccr_step #(
        .DRIVE_BITS(DRIVE_BITS)
    ) u_step (
        .i_cfg             (r_cfg),
        .i_ctl             (r_ctl),
        .i_drive           (r_drive),
        .i_opcode          (r_opcode),
        .i_meas_voltage_mv (r_volt),
        .i_meas_current_ma (r_cur),
        .o_ctl             (w_ctl),
        .o_drive           (w_drive),
        .o_emit            (w_emit)
    );

    assign o_out_valid = (r_cnt != 2'd0);
    assign w_pop       = o_out_valid && i_out_ready;
    assign w_free      = (r_cnt == 2'd0) || (r_cnt == 2'd1 && i_out_ready);
    assign w_advance   = r_in_valid && ((w_emit.count == 2'd0) || w_free);
    assign w_load      = w_advance && (w_emit.count != 2'd0);
    assign o_in_ready  = !r_in_valid || w_advance;

    always_comb begin
        n_cnt = r_cnt;
        if (w_pop) begin
            n_cnt = r_cnt - 2'd1;
        end
        if (w_load) begin
            n_cnt = w_emit.count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                ccr_pkg::REG_CC_CURRENT:     r_cfg.cc_current_ma     <= i_cfg_data[14:0];
                ccr_pkg::REG_CV_VOLTAGE:     r_cfg.cv_voltage_mv     <= i_cfg_data;
                ccr_pkg::REG_CC_END_VOLTAGE: r_cfg.cc_end_voltage_mv <= i_cfg_data;
                ccr_pkg::REG_CV_END_CURRENT: r_cfg.cv_end_current_ma <= i_cfg_data[14:0];
                ccr_pkg::REG_DEAD_BAND:      r_cfg.dead_band         <= i_cfg_data[11:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in_valid && o_in_ready) begin
            r_in_valid <= 1'b1;
        end else if (w_advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_opcode <= i_opcode;
            r_volt   <= i_meas_voltage_mv;
            r_cur    <= i_meas_current_ma;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl.mode    <= ccr_pkg::MODE_IDLE;
            r_ctl.phase   <= ccr_pkg::PHASE_CC;
            r_ctl.seconds <= '0;
            r_drive       <= DriveMax;
            r_cnt         <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
            if (w_advance) begin
                r_ctl   <= w_ctl;
                r_drive <= w_drive;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_stop <= w_emit.stop;
            r_word <= w_emit.word;
            r_secs <= w_emit.secs;
        end
    end

    // output mux: the DAC word, or for a stop burst the done report, then the two off words
    always_comb begin
        o_kind            = ccr_pkg::KIND_DAC[0];
        o_spi_word        = r_word;
        o_elapsed_seconds = '0;
        o_last            = 1'b1;
        if (r_stop) begin
            case (r_cnt)
                2'd3: begin
                    o_kind            = ccr_pkg::KIND_DONE;
                    o_spi_word        = '0;
                    o_elapsed_seconds = r_secs;
                    o_last            = 1'b0;
                end
                2'd2: begin
                    o_spi_word = ccr_pkg::OFF_WORD_A;
                    o_last     = 1'b0;
                end
                default: begin
                    o_spi_word = ccr_pkg::OFF_WORD_B;
                end
            endcase
        end
    end

    `CCR_ASSERT_NOW(a_burst3_is_stop, i_clk, i_rst_n, r_cnt == 2'd3, r_stop)
    `CCR_ASSERT_NOW(a_done_not_last, i_clk, i_rst_n, o_out_valid && o_kind, !o_last)
    `CCR_ASSERT_NEXT(a_held_item_kept, i_clk, i_rst_n, r_in_valid && !w_advance, r_in_valid)
    `CCR_ASSERT_NEXT(a_burst_stalls, i_clk, i_rst_n, o_out_valid && !i_out_ready, $stable(r_cnt))
    `CCR_ASSERT_NOW(a_no_overwrite, i_clk, i_rst_n, w_load, r_cnt == 2'd0 || w_pop)

endmodule

@@ tb/sv/cc_cv_charge_regulator_tb.sv @@
// Self-checking testbench for cc_cv_charge_regulator: charge sequences go in, DAC words
// and done reports are predicted in-line and compared beat by beat.
// Depends on ccr_pkg and the cc_cv_charge_regulator RTL.
`timescale 1ns / 1ps

module cc_cv_charge_regulator_tb;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int DRIVE_FULL = (1 << ccr_pkg::LEVEL_BITS) - 1;
    localparam int STALL_LIMIT = 2000;
    localparam int SQUEEZE_CYCLES = 100;
    localparam int SETTLE_CYCLES = 8;

    typedef struct packed {
        logic [1:0]  op;
        logic [15:0] volt;
        logic [15:0] cur;
    } t_item;

    typedef struct packed {
        logic        kind;
        logic [15:0] word;
        logic [31:0] secs;
        logic        last;
    } t_beat;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_we = 1'b0;
    logic [2:0]         i_cfg_idx = '0;
    logic [15:0]        i_cfg_data = '0;
    logic               i_in_valid = 1'b0;
    logic               o_in_ready;
    logic [1:0]         i_opcode = '0;
    logic [15:0]        i_meas_voltage_mv = '0;
    logic signed [15:0] i_meas_current_ma = '0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    logic               o_kind;
    logic [15:0]        o_spi_word;
    logic [31:0]        o_elapsed_seconds;
    logic               o_last;

    cc_cv_charge_regulator i_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_data        (i_cfg_data),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_opcode          (i_opcode),
        .i_meas_voltage_mv (i_meas_voltage_mv),
        .i_meas_current_ma (i_meas_current_ma),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_kind            (o_kind),
        .o_spi_word        (o_spi_word),
        .o_elapsed_seconds (o_elapsed_seconds),
        .o_last            (o_last)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // charger model state
    ccr_pkg::t_cfg chg_cfg = '0;
    logic [1:0]  chg_mode = ccr_pkg::MODE_IDLE;
    logic        chg_phase = ccr_pkg::PHASE_CC;
    int          drive_lvl = DRIVE_FULL;
    logic [31:0] elapsed = '0;

    t_item item_q[$];
    t_beat charger_out_q[$];
    t_item cur_item;
    int    items_queued = 0;
    int    errors = 0;
    int    in_gap = 0;
    int    out_hold = 0;
    int    beats_seen = 0;
    int    next_squeeze = 60;
    int    stall_cycles = 0;
    bit    no_idle = 1'b0;

    function automatic t_beat mk_beat(logic kind, logic [15:0] word, logic [31:0] secs,
                                      logic last);
        t_beat b;
        b.kind = kind;
        b.word = word;
        b.secs = secs;
        b.last = last;
        return b;
    endfunction

    // step the drive toward the target; 10 for large errors, 1 otherwise
    task automatic adjust_drive(int err);
        int tol;
        int rate;
        tol = int'(chg_cfg.dead_band);
        rate = (err >= 100 || err <= -100) ? 10 : 1;
        if (err > tol && drive_lvl > 0)
            drive_lvl = (drive_lvl > rate) ? drive_lvl - rate : 0;
        if (err < -tol && drive_lvl < DRIVE_FULL)
            drive_lvl = (DRIVE_FULL - drive_lvl > rate) ? drive_lvl + rate : DRIVE_FULL;
    endtask

    task automatic charger_step(t_item it);
        int  volt;
        int  cur;
        int  mag;
        bit  leave;
        volt = it.volt;
        cur = $signed(it.cur);
        case (it.op)
            ccr_pkg::OP_START: chg_mode = ccr_pkg::MODE_STARTING;
            ccr_pkg::OP_TICK: begin
                if ((chg_mode == ccr_pkg::MODE_REGULATING
                     || chg_mode == ccr_pkg::MODE_STOPPING) && elapsed != '1)
                    elapsed++;
            end
            ccr_pkg::OP_SAMPLE: begin
                case (chg_mode)
                    ccr_pkg::MODE_STARTING: begin
                        drive_lvl = DRIVE_FULL;
                        chg_phase = ccr_pkg::PHASE_CC;
                        elapsed = '0;
                        chg_mode = ccr_pkg::MODE_REGULATING;
                    end
                    ccr_pkg::MODE_REGULATING: begin
                        if (chg_phase == ccr_pkg::PHASE_CC) begin
                            leave = volt >= int'(chg_cfg.cc_end_voltage_mv);
                        end else begin
                            mag = (cur < 0) ? -cur : cur;
                            leave = mag <= int'(chg_cfg.cv_end_current_ma);
                        end
                        if (leave) begin
                            if (chg_phase == ccr_pkg::PHASE_CC)
                                chg_phase = ccr_pkg::PHASE_CV;
                            else
                                chg_mode = ccr_pkg::MODE_STOPPING;
                        end else begin
                            if (chg_phase == ccr_pkg::PHASE_CC)
                                adjust_drive(int'(chg_cfg.cc_current_ma) - cur);
                            else
                                adjust_drive(int'(chg_cfg.cv_voltage_mv) - volt);
                            charger_out_q.push_back(mk_beat(1'(ccr_pkg::KIND_DAC),
                                ccr_pkg::WORD_ACTIVE
                                | 16'(drive_lvl[ccr_pkg::LEVEL_BITS-1:0]), '0, 1'b1));
                        end
                    end
                    ccr_pkg::MODE_STOPPING: begin
                        charger_out_q.push_back(mk_beat(ccr_pkg::KIND_DONE, '0, elapsed,
                                                        1'b0));
                        charger_out_q.push_back(mk_beat(1'(ccr_pkg::KIND_DAC),
                                                        ccr_pkg::OFF_WORD_A, '0, 1'b0));
                        charger_out_q.push_back(mk_beat(1'(ccr_pkg::KIND_DAC),
                                                        ccr_pkg::OFF_WORD_B, '0, 1'b1));
                        chg_mode = ccr_pkg::MODE_IDLE;
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
    endtask

    // input driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready)
                charger_step(cur_item);
            if (!i_in_valid || o_in_ready) begin
                if (in_gap > 0) begin
                    in_gap--;
                    i_in_valid <= 1'b0;
                end else if (item_q.size() == 0) begin
                    i_in_valid <= 1'b0;
                end else if (!no_idle && $urandom_range(0, 11) == 0) begin
                    in_gap = $urandom_range(0, 13);
                    i_in_valid <= 1'b0;
                end else begin
                    cur_item = item_q.pop_front();
                    i_in_valid <= 1'b1;
                    i_opcode <= cur_item.op;
                    i_meas_voltage_mv <= cur_item.volt;
                    i_meas_current_ma <= cur_item.cur;
                end
            end
        end
    end

    // result monitor and receiver stalls
    always @(posedge i_clk) begin
        t_beat want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            beats_seen++;
            if (charger_out_q.size() == 0) begin
                $error("unexpected beat: kind %0d, spi_word %h", o_kind, o_spi_word);
                errors++;
            end else begin
                want = charger_out_q.pop_front();
                if (o_kind !== want.kind) begin
                    $error("kind: expected %0d, got %0d", want.kind, o_kind);
                    errors++;
                end
                if (o_spi_word !== want.word) begin
                    $error("spi_word: expected %h, got %h", want.word, o_spi_word);
                    errors++;
                end
                if (o_elapsed_seconds !== want.secs) begin
                    $error("elapsed_seconds: expected %0d, got %0d", want.secs,
                           o_elapsed_seconds);
                    errors++;
                end
                if (o_last !== want.last) begin
                    $error("last: expected %0d, got %0d", want.last, o_last);
                    errors++;
                end
            end
        end
        if (out_hold > 0) begin
            out_hold--;
            i_out_ready <= 1'b0;
        end else if (i_rst_n && !no_idle && beats_seen >= next_squeeze) begin
            // long back-pressure so the block fills and stalls its input
            next_squeeze = beats_seen + 200;
            out_hold = SQUEEZE_CYCLES - 1;
            i_out_ready <= 1'b0;
        end else if (!no_idle && $urandom_range(0, 9) == 0) begin
            out_hold = $urandom_range(0, 13);
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    task automatic queue_item(logic [1:0] op, int v, int c);
        t_item it;
        it.op = op;
        it.volt = 16'(v);
        it.cur = 16'(c);
        item_q.push_back(it);
        items_queued++;
    endtask

    function automatic int clip_near(int center, int spread, int lo, int hi);
        int v;
        v = center + $urandom_range(0, 2 * spread) - spread;
        return (v < lo) ? lo : (v > hi) ? hi : v;
    endfunction

    function automatic int signed_mag(int m);
        if (m > 32767 || $urandom_range(0, 1) == 0)
            return -m;
        return m;
    endfunction

    // one well-formed charge: arm, init, CC regulation, CV switch, CV regulation,
    // end of charge, stop burst; spread 0 means full-range current in CC
    task automatic queue_charge(int n_cc, int n_cv, int spread);
        int v;
        int c;
        int cc_end;
        int cv_end;
        cc_end = chg_cfg.cc_end_voltage_mv;
        cv_end = chg_cfg.cv_end_current_ma;
        queue_item(ccr_pkg::OP_START, $urandom_range(0, 65535), $urandom_range(0, 65535));
        queue_item(ccr_pkg::OP_SAMPLE, $urandom_range(0, 65535), $urandom_range(0, 65535));
        repeat (n_cc) begin
            if ($urandom_range(0, 9) == 0) begin
                queue_item(ccr_pkg::OP_TICK, $urandom_range(0, 65535),
                           $urandom_range(0, 65535));
            end else begin
                v = (cc_end == 0) ? 0 : $urandom_range(0, cc_end - 1);
                c = (spread == 0) ? $urandom_range(0, 65535) :
                    clip_near(chg_cfg.cc_current_ma, spread, -32768, 32767);
                queue_item(ccr_pkg::OP_SAMPLE, v, c);
            end
        end
        queue_item(ccr_pkg::OP_SAMPLE, $urandom_range(cc_end, 65535), $urandom_range(0, 65535));
        repeat (n_cv) begin
            if ($urandom_range(0, 5) == 0) begin
                queue_item(ccr_pkg::OP_TICK, $urandom_range(0, 65535),
                           $urandom_range(0, 65535));
            end else begin
                c = signed_mag($urandom_range(cv_end + 1, 32768));
                v = clip_near(chg_cfg.cv_voltage_mv, (spread == 0) ? 30000 : spread, 0, 65535);
                queue_item(ccr_pkg::OP_SAMPLE, v, c);
            end
        end
        queue_item(ccr_pkg::OP_SAMPLE, $urandom_range(0, 65535),
                   signed_mag($urandom_range(0, cv_end)));
        if ($urandom_range(0, 1) == 0)
            queue_item(ccr_pkg::OP_TICK, $urandom_range(0, 65535), $urandom_range(0, 65535));
        queue_item(ccr_pkg::OP_SAMPLE, $urandom_range(0, 65535), $urandom_range(0, 65535));
    endtask

    task automatic queue_mix(int n, int spread);
        int first;
        first = items_queued;
        while (items_queued - first < n) begin
            if ($urandom_range(0, 5) == 0)
                queue_item(2'($urandom_range(0, 3)), $urandom_range(0, 65535),
                           $urandom_range(0, 65535));
            else
                queue_charge($urandom_range(2, 16), $urandom_range(2, 16), spread);
        end
    endtask

    task automatic put_reg(logic [2:0] idx, logic [15:0] data);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
    endtask

    task automatic write_cfg(int cc_i, int cv_v, int cc_end_v, int cv_end_i, int band);
        put_reg(ccr_pkg::REG_CC_CURRENT, 16'(cc_i));
        put_reg(ccr_pkg::REG_CV_VOLTAGE, 16'(cv_v));
        put_reg(ccr_pkg::REG_CC_END_VOLTAGE, 16'(cc_end_v));
        put_reg(ccr_pkg::REG_CV_END_CURRENT, 16'(cv_end_i));
        put_reg(ccr_pkg::REG_DEAD_BAND, 16'(band));
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        chg_cfg.cc_current_ma = 15'(cc_i);
        chg_cfg.cv_voltage_mv = 16'(cv_v);
        chg_cfg.cc_end_voltage_mv = 16'(cc_end_v);
        chg_cfg.cv_end_current_ma = 15'(cv_end_i);
        chg_cfg.dead_band = 12'(band);
    endtask

    // wait until every item is sent and every result has come, then let the block settle
    task automatic drain;
        while (item_q.size() != 0 || i_in_valid || charger_out_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        write_cfg(1000, 4200, 4100, 50, 5);
        queue_item(OP_UNUSED, 16'hFFFF, 16'hFFFF);            // unknown opcode
        queue_item(ccr_pkg::OP_SAMPLE, 1234, 100);            // sample while idle
        queue_item(ccr_pkg::OP_TICK, 0, 0);                   // tick while idle
        queue_item(ccr_pkg::OP_START, 0, 0);
        queue_item(ccr_pkg::OP_TICK, 0, 0);                   // tick while armed
        queue_item(ccr_pkg::OP_SAMPLE, 0, -32768);            // init sample
        queue_item(ccr_pkg::OP_SAMPLE, 0, -32768);            // huge positive error
        queue_item(ccr_pkg::OP_SAMPLE, 0, 32767);             // huge negative error, clamps high
        queue_item(ccr_pkg::OP_SAMPLE, 100, 1000);            // zero error
        queue_item(ccr_pkg::OP_SAMPLE, 100, 1003);            // inside dead band
        queue_item(ccr_pkg::OP_SAMPLE, 100, 990);             // small step down
        queue_item(ccr_pkg::OP_SAMPLE, 100, 900);             // error of exactly 100
        queue_item(ccr_pkg::OP_SAMPLE, 100, 1099);            // error of -99
        queue_item(ccr_pkg::OP_TICK, 0, 0);
        queue_item(ccr_pkg::OP_TICK, 0, 0);
        queue_item(ccr_pkg::OP_SAMPLE, 4100, 0);              // voltage at CC cutoff
        queue_item(ccr_pkg::OP_SAMPLE, 65535, 32767);
        queue_item(ccr_pkg::OP_SAMPLE, 0, -32768);
        queue_item(ccr_pkg::OP_SAMPLE, 4200, 51);             // just above end current
        queue_item(ccr_pkg::OP_START, 16'hFFFF, 16'hFFFF);    // restart while busy
        queue_item(ccr_pkg::OP_SAMPLE, 0, 0);
        queue_item(ccr_pkg::OP_SAMPLE, 65535, 0);
        queue_item(ccr_pkg::OP_TICK, 0, 0);
        queue_item(ccr_pkg::OP_SAMPLE, 4000, -50);            // magnitude at end current
        queue_item(ccr_pkg::OP_SAMPLE, 65535, 32767);         // stop burst
        drain();

        write_cfg(32767, 65535, 65535, 32767, 4095);
        queue_mix(15, 300);
        drain();

        write_cfg(0, 0, 0, 0, 0);
        queue_mix(15, 300);
        drain();

        // long CC run that walks the drive down to zero
        write_cfg(32767, $urandom_range(0, 65535), 65535, $urandom_range(0, 2000),
                  $urandom_range(0, 50));
        queue_charge(480, 4, 0);
        drain();

        write_cfg($urandom_range(0, 32767), $urandom_range(0, 65535), $urandom_range(0, 65535),
                  $urandom_range(0, 32767), $urandom_range(0, 200));
        no_idle = 1'b1;
        queue_mix(20, 300);
        drain();

        repeat (20) @(posedge i_clk);
        if (charger_out_q.size() != 0) begin
            $error("%0d expected beats never arrived", charger_out_q.size());
            errors++;
        end
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+sv
sv/ccr_pkg.sv
sv/ccr_step.sv
sv/cc_cv_charge_regulator.sv
tb/sv/cc_cv_charge_regulator_tb.sv
